// ===== design/cclt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cclt_pkg
// Shared types and constants of the LRU cache tag directory.
// ----------------------------------------------------------------------------
package cclt_pkg;

    localparam int TAG_W       = 16;
    localparam int STAMP_W     = 32;
    localparam int CNT_W       = 32;
    localparam int OP_W        = 2;
    localparam int SLOT_OUT_W  = 4;
    localparam int OUT_TDATA_W = 72;

    localparam logic [STAMP_W-1:0] STAMP_MAX = 32'hFFFF_FFFF;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_FILL   = 2'd1,
        OP_INVAL  = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== design/config_cache_lru_tags.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// config_cache_lru_tags
// Tag directory of a fully associative cache with LRU replacement.
// ----------------------------------------------------------------------------
// One item is taken at a time. A lookup or an invalidate walks the slots one
// per cycle through a single tag and stamp compare unit, reading the tag and
// stamp memories at one address a cycle; a lookup or an invalidate that
// matches stops early. A fill does one tag read of the claimed slot, and a
// clear or a lookup while caching is disabled goes straight to the done state.
// The result is held in an output register, so the next item is accepted
// while a result waits. Valid bits and stamp-written bits live in flip-flops,
// so a clear takes effect at once; a slot whose stamp was never written
// since the last clear reads as stamp zero. Input tdata holds bus, device,
// function; tuser holds the operation.
// ----------------------------------------------------------------------------
module config_cache_lru_tags
    import cclt_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Configuration: cache_enable.
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic                   i_cfg_data,
    // Input item.
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // tdata: bus_num [7:0], dev_num [12:8], func_num [15:13]
    input  wire logic [TAG_W-1:0]       i_s_tdata,
    // tuser: op [1:0]
    input  wire logic [OP_W-1:0]        i_s_tuser,
    // Result item.
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // tdata: hit [0], slot [4:1], found [5], hit_total [37:6],
    // miss_total [69:38], zero [71:70]
    output logic [OUT_TDATA_W-1:0]      o_m_tdata
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    // Memories.
    logic [TAG_W-1:0]   m_tag   [NUM_SLOTS];
    logic [STAMP_W-1:0] m_stamp [NUM_SLOTS];
    logic [TAG_W-1:0]   r_tag_rd;
    logic [STAMP_W-1:0] r_stamp_rd;

    // Control and state registers.
    t_state              r_state,        n_state;
    t_op                 r_op,           n_op;
    logic [TAG_W-1:0]    r_tag,          n_tag;
    logic [SLOT_W-1:0]   r_idx,          n_idx;
    logic                r_have,         n_have;
    logic [SLOT_W-1:0]   r_best,         n_best;
    logic [STAMP_W-1:0]  r_best_stamp,   n_best_stamp;
    logic [NUM_SLOTS-1:0] r_valid,       n_valid;
    logic [NUM_SLOTS-1:0] r_sw,          n_sw;
    logic [CNT_W-1:0]    r_access,       n_access;
    logic [CNT_W-1:0]    r_hits,         n_hits;
    logic [CNT_W-1:0]    r_misses,       n_misses;
    logic                r_enable,       n_enable;
    logic                r_claim_live,   n_claim_live;
    logic [SLOT_W-1:0]   r_claim_at,     n_claim_at;
    logic                r_res_hit,      n_res_hit;
    logic [SLOT_W-1:0]   r_res_slot,     n_res_slot;
    logic                r_res_found,    n_res_found;
    logic                r_out_valid,    n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data,  n_out_data;

    // Memory port controls.
    logic [SLOT_W-1:0]   w_rd_addr;
    logic                w_tag_we;
    logic [SLOT_W-1:0]   w_tag_waddr;
    logic                w_stamp_we;
    logic [SLOT_W-1:0]   w_stamp_waddr;
    logic [STAMP_W-1:0]  w_stamp_wdata;

    // Shared compare unit for the entry under the scan.
    logic                w_ent_valid;
    logic [STAMP_W-1:0]  w_ent_stamp;
    logic                w_match;
    logic                w_take;
    logic                w_have_nx;
    logic [SLOT_W-1:0]   w_best_nx;
    logic [SLOT_W+SLOT_OUT_W-1:0] w_slot_ext;
    logic                w_in_acc;
    t_op                 w_in_op;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    assign w_in_acc = i_s_tvalid && (r_state == S_IDLE);
    assign w_in_op  = t_op'(i_s_tuser);

    assign w_ent_valid   = r_valid[r_idx];
    assign w_ent_stamp   = r_sw[r_idx] ? r_stamp_rd : '0;
    assign w_match       = w_ent_valid && (r_tag_rd == r_tag);
    assign w_take        = !w_ent_valid || (w_ent_stamp < r_best_stamp);
    assign w_have_nx     = r_have || w_take;
    assign w_best_nx     = w_take ? r_idx : r_best;
    assign w_stamp_wdata = r_access + CNT_W'(1);
    assign w_slot_ext    = {{SLOT_OUT_W{1'b0}}, r_res_slot};

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_tag        = r_tag;
        n_idx        = r_idx;
        n_have       = r_have;
        n_best       = r_best;
        n_best_stamp = r_best_stamp;
        n_valid      = r_valid;
        n_sw         = r_sw;
        n_access     = r_access;
        n_hits       = r_hits;
        n_misses     = r_misses;
        n_enable     = r_enable;
        n_claim_live = r_claim_live;
        n_claim_at   = r_claim_at;
        n_res_hit    = r_res_hit;
        n_res_slot   = r_res_slot;
        n_res_found  = r_res_found;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_data   = r_out_data;

        w_rd_addr     = r_idx + SLOT_W'(1);
        w_tag_we      = 1'b0;
        w_tag_waddr   = w_best_nx;
        w_stamp_we    = 1'b0;
        w_stamp_waddr = r_idx;

        case (r_state)
            S_IDLE: begin
                w_rd_addr = (w_in_op == OP_FILL) ? r_claim_at : '0;
                if (w_in_acc) begin
                    n_op         = w_in_op;
                    n_tag        = {i_s_tdata[7:0], i_s_tdata[12:8], i_s_tdata[15:13]};
                    n_idx        = '0;
                    n_have       = 1'b0;
                    n_best       = '0;
                    n_best_stamp = STAMP_MAX;
                    n_res_hit    = 1'b0;
                    n_res_slot   = '0;
                    n_res_found  = 1'b0;
                    case (w_in_op)
                        OP_LOOKUP: n_state = r_enable ? S_SCAN : S_DONE;
                        OP_FILL:   n_state = S_FILL;
                        OP_INVAL:  n_state = S_SCAN;
                        OP_CLEAR: begin
                            n_valid      = '0;
                            n_sw         = '0;
                            n_access     = '0;
                            n_claim_live = 1'b0;
                            n_claim_at   = '0;
                            n_hits       = '0;
                            n_misses     = '0;
                            n_state      = S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end

            S_SCAN: begin
                if (w_match) begin
                    n_res_slot = r_idx;
                    n_state    = S_DONE;
                    if (r_op == OP_LOOKUP) begin
                        w_stamp_we     = 1'b1;
                        w_stamp_waddr  = r_idx;
                        n_sw[r_idx]    = 1'b1;
                        n_access       = w_stamp_wdata;
                        n_hits         = r_hits + CNT_W'(1);
                        n_res_hit      = 1'b1;
                    end else begin
                        n_valid[r_idx] = 1'b0;
                        n_res_found    = 1'b1;
                    end
                end else begin
                    n_have = w_have_nx;
                    n_best = w_best_nx;
                    if (w_take) begin
                        n_best_stamp = w_ent_stamp;
                    end
                    if (r_idx == LAST_SLOT) begin
                        n_state = S_DONE;
                        if (r_op == OP_LOOKUP) begin
                            n_misses = r_misses + CNT_W'(1);
                            if (w_have_nx) begin
                                // Claim the victim: new tag, held invalid until filled.
                                w_tag_we           = 1'b1;
                                n_valid[w_best_nx] = 1'b0;
                                n_claim_live       = 1'b1;
                                n_claim_at         = w_best_nx;
                                n_res_slot         = w_best_nx;
                            end else begin
                                n_claim_live = 1'b0;
                                n_claim_at   = '0;
                            end
                        end
                    end else begin
                        n_idx = r_idx + SLOT_W'(1);
                    end
                end
            end

            S_FILL: begin
                if (r_claim_live && (r_tag_rd == r_tag)) begin
                    w_stamp_we          = 1'b1;
                    w_stamp_waddr       = r_claim_at;
                    n_valid[r_claim_at] = 1'b1;
                    n_sw[r_claim_at]    = 1'b1;
                    n_access            = w_stamp_wdata;
                    n_res_found         = 1'b1;
                    n_res_slot          = r_claim_at;
                    n_claim_live        = 1'b0;
                end
                n_state = S_DONE;
            end

            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {2'b00, r_misses, r_hits, r_res_found,
                                   w_slot_ext[SLOT_OUT_W-1:0], r_res_hit};
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase

        // Disabling the cache empties the directory but keeps the totals.
        if (i_cfg_valid) begin
            n_enable = i_cfg_data;
            if (!i_cfg_data) begin
                n_valid      = '0;
                n_sw         = '0;
                n_access     = '0;
                n_claim_live = 1'b0;
                n_claim_at   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_sw         <= '0;
            r_access     <= '0;
            r_hits       <= '0;
            r_misses     <= '0;
            r_enable     <= 1'b1;
            r_claim_live <= 1'b0;
            r_claim_at   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_valid      <= n_valid;
            r_sw         <= n_sw;
            r_access     <= n_access;
            r_hits       <= n_hits;
            r_misses     <= n_misses;
            r_enable     <= n_enable;
            r_claim_live <= n_claim_live;
            r_claim_at   <= n_claim_at;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_tag        <= n_tag;
        r_idx        <= n_idx;
        r_have       <= n_have;
        r_best       <= n_best;
        r_best_stamp <= n_best_stamp;
        r_res_hit    <= n_res_hit;
        r_res_slot   <= n_res_slot;
        r_res_found  <= n_res_found;
        r_out_data   <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (w_tag_we) begin
            m_tag[w_tag_waddr] <= r_tag;
        end
        r_tag_rd <= m_tag[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_stamp_we) begin
            m_stamp[w_stamp_waddr] <= w_stamp_wdata;
        end
        r_stamp_rd <= m_stamp[w_rd_addr];
    end

endmodule
`default_nettype wire
